[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the RTL folder.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/mmr_pkg.sv]
// Types and constants of the multiprecision multiply-accumulate row.
// Depends on nothing; used by every module of the block.
package mmr_pkg;

    localparam int WORD_BITS = 32;
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
    localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

    typedef logic [WORD_BITS-1:0]   word_t;
    typedef logic [2*WORD_BITS-1:0] prod_t;

    // Operation codes carried on the cmd field.
    typedef enum logic [1:0] {
        CMD_MAC  = 2'd0,
        CMD_SQR  = 2'd1,
        CMD_DBL  = 2'd2,
        CMD_PROP = 2'd3
    } cmd_t;

    // One operation after the multiply stage.
    typedef struct packed {
        cmd_t  cmd;
        logic  first;
        logic  last;
        word_t dst;
        word_t dst_first;
        prod_t prod;
    } mmr_op_t;

    // One result item.
    typedef struct packed {
        word_t word;
        word_t carry;
        logic  last;
    } mmr_res_t;

endpackage

[rtl/multiprecision_mac_row.sv]
// Top level of the multiprecision multiply-accumulate row kernel.
// Depends on mmr_pkg, mmr_mul_stage, mmr_acc_stage and mmr_res_fifo.
//
// Channel  Handshake              Payload
// in       in_valid / in_ready    cmd, first, last, src_word, dst_word, dst_first_word
// out      out_valid / out_ready  result_word, carry_out, last_of_run
// cfg      cfg_valid / cfg_ready  multiplier
//
// An item's first result is offered once it has passed the input register, the product
// register and the carry loop's write into the result queue.
// One item is accepted per cycle while in_ready is high; square items and closing doubled
// items give two results, so the out channel (one result per cycle) sets the rate for them.
// Reset clears the carry, the pending word, the multiplier and all valid flags.
// A stalled out channel fills the four-entry queue, then backs up into the input.
module multiprecision_mac_row
    import mmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic        first,
    input  logic        last,
    input  logic [31:0] src_word,
    input  logic [31:0] dst_word,
    input  logic [31:0] dst_first_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_word,
    output logic [31:0] carry_out,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] multiplier
);

    word_t    multiplier_reg;
    logic     op_valid;
    mmr_op_t  op;
    logic     op_take;
    logic     space_ok;
    logic     push_two;
    mmr_res_t res0;
    mmr_res_t res1;
    mmr_res_t head;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            multiplier_reg <= '0;
        end
        else if (cfg_valid)
        begin
            multiplier_reg <= multiplier;
        end
    end

    // Input register and multiplier.
    mmr_mul_stage u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_cmd       (cmd_t'(cmd)),
        .in_first     (first),
        .in_last      (last),
        .in_src       (src_word),
        .in_dst       (dst_word),
        .in_dst_first (dst_first_word),
        .multiplier   (multiplier_reg),
        .op_valid     (op_valid),
        .op           (op),
        .op_take      (op_take)
    );

    // Carry loop.
    mmr_acc_stage u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .space_ok (space_ok),
        .op_take  (op_take),
        .push_two (push_two),
        .res0     (res0),
        .res1     (res1)
    );

    // Result queue.
    mmr_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (op_take),
        .push_two  (push_two),
        .res0      (res0),
        .res1      (res1),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign result_word = head.word;
    assign carry_out   = head.carry;
    assign last_of_run = head.last;

endmodule

[rtl/mmr_mul_stage.sv]
// Input register and the word multiplier with its product register.
// Depends on mmr_pkg.
module mmr_mul_stage
    import mmr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  cmd_t    in_cmd,
    input  logic    in_first,
    input  logic    in_last,
    input  word_t   in_src,
    input  word_t   in_dst,
    input  word_t   in_dst_first,
    input  word_t   multiplier,
    output logic    op_valid,
    output mmr_op_t op,
    input  logic    op_take
);

    logic    a_valid_reg, a_valid_next;
    cmd_t    a_cmd_reg;
    logic    a_first_reg;
    logic    a_last_reg;
    word_t   a_src_reg;
    word_t   a_dst_reg;
    word_t   a_dst_first_reg;
    logic    b_valid_reg, b_valid_next;
    mmr_op_t b_op_reg;
    mmr_op_t b_op_next;
    logic    a_adv;
    word_t   factor;

    // Stage A moves on when stage B is empty or is being drained.
    assign a_adv    = !b_valid_reg || op_take;
    assign in_ready = !a_valid_reg || a_adv;

    // Squares use the source word twice; every other command uses the multiplier.
    assign factor = (a_cmd_reg == CMD_SQR) ? a_src_reg : multiplier;

    always_comb
    begin
        b_op_next.cmd       = a_cmd_reg;
        b_op_next.first     = a_first_reg;
        b_op_next.last      = a_last_reg;
        b_op_next.dst       = a_dst_reg;
        b_op_next.dst_first = a_dst_first_reg;
        b_op_next.prod      = prod_t'(factor) * prod_t'(a_src_reg);
    end

    always_comb
    begin
        a_valid_next = in_ready ? in_valid : a_valid_reg;
        b_valid_next = a_adv ? a_valid_reg : b_valid_reg;
    end

    // Valid flags of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Payload of stage A loads on each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_cmd_reg       <= in_cmd;
            a_first_reg     <= in_first;
            a_last_reg      <= in_last;
            a_src_reg       <= in_src;
            a_dst_reg       <= in_dst;
            a_dst_first_reg <= in_dst_first;
        end
    end

    // Product register.
    always_ff @(posedge clk)
    begin
        if (a_adv && a_valid_reg)
        begin
            b_op_reg <= b_op_next;
        end
    end

    assign op_valid = b_valid_reg;
    assign op       = b_op_reg;

endmodule

[rtl/mmr_acc_stage.sv]
// Carry loop: adds the product into the accumulator words and keeps the carry
// and the pending word of doubled rows. Depends on mmr_pkg.
module mmr_acc_stage
    import mmr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     op_valid,
    input  mmr_op_t  op,
    input  logic     space_ok,
    output logic     op_take,
    output logic     push_two,
    output mmr_res_t res0,
    output mmr_res_t res1
);

    word_t carry_reg, carry_next;
    word_t pending_reg, pending_next;

    word_t               c_in;
    word_t               pend;
    word_t               prod_lo;
    word_t               prod_hi;
    logic [2*WORD_BITS:0] mac_sum;
    logic [WORD_BITS:0]   lo_sum;
    word_t               carry_mid;
    logic [WORD_BITS:0]   up_sum;
    logic [WORD_BITS:0]   up_fin;
    logic [WORD_BITS:0]   prop_sum;

    assign op_take = op_valid && space_ok;
    assign prod_lo = op.prod[WORD_BITS-1:0];
    assign prod_hi = op.prod[2*WORD_BITS-1:WORD_BITS];
    assign c_in    = op.first ? '0 : carry_reg;
    assign pend    = op.first ? op.dst_first : pending_reg;

    // Adders of every command; the case below picks what is used.
    always_comb
    begin
        mac_sum   = (2*WORD_BITS+1)'(op.prod) + (2*WORD_BITS+1)'(op.dst)
                  + (2*WORD_BITS+1)'(c_in);
        lo_sum    = {1'b0, prod_lo[WORD_BITS-2:0], 1'b0} + {1'b0, pend};
        carry_mid = c_in + WORD_BITS'(prod_lo[WORD_BITS-1]) + WORD_BITS'(lo_sum[WORD_BITS]);
        up_sum    = {1'b0, prod_hi[WORD_BITS-2:0], 1'b0} + {1'b0, op.dst};
        up_fin    = {1'b0, up_sum[WORD_BITS-1:0]} + {1'b0, carry_mid};
        prop_sum  = {1'b0, op.dst} + {1'b0, c_in};
    end

    // Results and next state for the current operation.
    always_comb
    begin
        carry_next   = carry_reg;
        pending_next = pending_reg;
        push_two     = 1'b0;
        res0.word    = '0;
        res0.carry   = '0;
        res0.last    = 1'b1;
        res1.word    = '0;
        res1.carry   = '0;
        res1.last    = 1'b1;
        case (op.cmd)
            CMD_MAC:
            begin
                carry_next = mac_sum[2*WORD_BITS-1:WORD_BITS];
                res0.word  = mac_sum[WORD_BITS-1:0];
                res0.carry = carry_next;
            end
            CMD_SQR:
            begin
                carry_next = c_in;
                push_two   = 1'b1;
                res0.word  = prod_lo;
                res0.carry = c_in;
                res0.last  = 1'b0;
                res1.word  = prod_hi;
                res1.carry = c_in;
            end
            CMD_DBL:
            begin
                carry_next   = WORD_BITS'(prod_hi[WORD_BITS-1]) + WORD_BITS'(up_sum[WORD_BITS])
                             + WORD_BITS'(up_fin[WORD_BITS]);
                pending_next = up_fin[WORD_BITS-1:0];
                push_two     = op.last;
                res0.word    = lo_sum[WORD_BITS-1:0];
                res0.carry   = carry_next;
                res0.last    = !op.last;
                res1.word    = up_fin[WORD_BITS-1:0];
                res1.carry   = carry_next;
            end
            CMD_PROP:
            begin
                carry_next = WORD_BITS'(prop_sum[WORD_BITS]);
                res0.word  = prop_sum[WORD_BITS-1:0];
                res0.carry = carry_next;
            end
            default:
            begin
                carry_next = carry_reg;
            end
        endcase
    end

    // Row state advances once per operation taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg   <= '0;
            pending_reg <= '0;
        end
        else if (op_take)
        begin
            carry_reg   <= carry_next;
            pending_reg <= pending_next;
        end
    end

endmodule

[rtl/mmr_res_fifo.sv]
// Result queue: takes one or two results per cycle while space_ok is high, and hands out
// one per cycle while out_ready is high. Depends on mmr_pkg.
module mmr_res_fifo
    import mmr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  logic     push_two,
    input  mmr_res_t res0,
    input  mmr_res_t res1,
    output logic     space_ok,
    output logic     out_valid,
    input  logic     out_ready,
    output mmr_res_t head
);

    mmr_res_t                mem [RES_DEPTH];
    logic [RES_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_BITS-1:0] count_reg, count_next;
    logic                    pop;
    logic                    wr1;
    logic [RES_PTR_BITS-1:0] wr_ptr_inc;

    // Room for two results is always demanded so a pair never splits.
    assign space_ok   = count_reg <= RES_CNT_BITS'(RES_DEPTH - 2);
    assign out_valid  = count_reg != '0;
    assign pop        = out_valid && out_ready;
    assign wr1        = push && push_two;
    assign wr_ptr_inc = wr_ptr_reg + RES_PTR_BITS'(1);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_BITS'(push) + RES_PTR_BITS'(wr1);
        rd_ptr_next = rd_ptr_reg + RES_PTR_BITS'(pop);
        count_next  = count_reg + RES_CNT_BITS'(push) + RES_CNT_BITS'(wr1)
                    - RES_CNT_BITS'(pop);
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= res0;
        end
        if (wr1)
        begin
            mem[wr_ptr_inc] <= res1;
        end
    end

endmodule

[rtl/mmr_checker.sv]
// Port-level checks of the multiprecision multiply-accumulate row.
// Depends on assert_macros.svh; bound to multiprecision_mac_row below.
`include "assert_macros.svh"

module mmr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result_word,
    input logic [31:0] carry_out,
    input logic        last_of_run
);

    // A stalled result stays offered and its word stays unchanged.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(result_word))

    // The second result of a pair is queued together with the first.
    `ASSERT_NEXT(a_pair_follows, clk, rst_n, out_valid && out_ready && !last_of_run, out_valid)

    // Both results of a pair report the same carry.
    `ASSERT_NEXT(a_pair_carry, clk, rst_n, out_valid && out_ready && !last_of_run, carry_out == $past(carry_out))

    // Configuration transactions are never refused.
    `ASSERT_IMPLY(a_cfg_taken, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind multiprecision_mac_row mmr_checker u_mmr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_word (result_word),
    .carry_out   (carry_out),
    .last_of_run (last_of_run)
);
